>>> rtl/d2py_pkg.sv
package d2py_pkg;

  localparam int unsigned ANG_W = 40;
  localparam int unsigned OPND_W = 64;
  localparam int unsigned DEG_W = 25;
  localparam logic [DEG_W-1:0] DEG360_Q16 = 25'd23592960;
  localparam logic [DEG_W-1:0] DEG270_Q16 = 25'd17694720;
  localparam logic [DEG_W-1:0] DEG90_Q16 = 25'd5898240;
  localparam logic signed [ANG_W-1:0] DEG180_Q24 = 40'sd3019898880;

  typedef struct packed {
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } dir_t;

  typedef struct packed {
    logic [DEG_W-1:0] pitch_deg;
    logic [DEG_W-1:0] yaw_deg;
  } angles_t;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic signed [ANG_W-1:0] atan_q24(input int unsigned i);
    logic signed [ANG_W-1:0] a;
    case (i)
      0: a = 40'sd754974720;
      1: a = 40'sd445687602;
      2: a = 40'sd235489088;
      3: a = 40'sd119537938;
      4: a = 40'sd60000934;
      5: a = 40'sd30029717;
      6: a = 40'sd15018523;
      7: a = 40'sd7509720;
      8: a = 40'sd3754917;
      9: a = 40'sd1877466;
      10: a = 40'sd938734;
      11: a = 40'sd469367;
      12: a = 40'sd234684;
      13: a = 40'sd117342;
      14: a = 40'sd58671;
      15: a = 40'sd29335;
      16: a = 40'sd14668;
      17: a = 40'sd7334;
      18: a = 40'sd3667;
      19: a = 40'sd1833;
      20: a = 40'sd917;
      21: a = 40'sd458;
      22: a = 40'sd229;
      23: a = 40'sd115;
      24: a = 40'sd57;
      25: a = 40'sd29;
      26: a = 40'sd14;
      27: a = 40'sd7;
      28: a = 40'sd4;
      29: a = 40'sd2;
      30: a = 40'sd1;
      default: a = 40'sd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/direction_to_pitch_yaw.sv
// direction vector to pitch and yaw in degrees
// input channel: dir (signed Q16.16 x, y, z) is taken on a clock edge with start high
//   and busy low; busy is always low, so an item may be offered every cycle
// output channel: angles (pitch_deg, yaw_deg, unsigned, 16 fraction bits, in [0,360))
//   is on the ports for exactly one cycle, marked by done
// pipeline, in order, with N = min(CORDIC_STAGES, 32): input register, squaring, sum,
//   32 root stages of one result bit each, operand setup, one stage per CORDIC
//   iteration (N in all), rounding, wrap; done is registered beside the wrapped angles
// throughput: one item per cycle; both atan2 evaluations run in parallel
//   CORDIC lanes, and the square root is a pipeline of 32 compare/subtract stages
// x = y = 0 gives pitch 270 when z > 0, else 90, and yaw 0
// reset: rst (synchronous) clears all valid bits; items in flight are dropped
// the receiver cannot stall: each result is taken in the cycle done is high
module direction_to_pitch_yaw #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  d2py_pkg::dir_t   dir,
  output logic             done,
  output d2py_pkg::angles_t angles
);

  localparam int unsigned N = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int unsigned ROOT_STEPS = 32;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } sq_t;

  typedef struct packed {
    logic signed [d2py_pkg::OPND_W-1:0] px;
    logic signed [d2py_pkg::OPND_W-1:0] py;
    logic signed [d2py_pkg::ANG_W-1:0] pa;
    logic signed [d2py_pkg::OPND_W-1:0] yx;
    logic signed [d2py_pkg::OPND_W-1:0] yy;
    logic signed [d2py_pkg::ANG_W-1:0] ya;
    logic vert;
    logic zpos;
  } cs_t;

  assign busy = 1'b0;

  // input register
  logic in_v;
  d2py_pkg::dir_t in_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= start;
    end
    in_d <= dir;
  end

  // squares
  logic mul_v;
  logic [63:0] xx, yy2;
  d2py_pkg::dir_t mul_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
    end else begin
      mul_v <= in_v;
    end
    xx <= 64'($signed(in_d.dir_x) * $signed(in_d.dir_x));
    yy2 <= 64'($signed(in_d.dir_y) * $signed(in_d.dir_y));
    mul_d <= in_d;
  end

  // sum, start of the root pipeline
  logic sq_v [0:ROOT_STEPS];
  sq_t sq [0:ROOT_STEPS];
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else begin
      sq_v[0] <= mul_v;
    end
    sq[0].rad <= xx + yy2;
    sq[0].rem <= '0;
    sq[0].root <= '0;
    sq[0].x <= mul_d.dir_x;
    sq[0].y <= mul_d.dir_y;
    sq[0].z <= mul_d.dir_z;
  end

  // one root bit per stage, two radicand bits in
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    logic [35:0] rem_sh, trial, diff;
    logic fits;
    always_comb begin
      rem_sh = {sq[k].rem, sq[k].rad[63:62]};
      trial = {2'b00, sq[k].root, 2'b01};
      diff = rem_sh - trial;
      fits = (rem_sh >= trial);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else begin
        sq_v[k+1] <= sq_v[k];
      end
      sq[k+1].rad <= {sq[k].rad[61:0], 2'b00};
      sq[k+1].rem <= fits ? diff[33:0] : rem_sh[33:0];
      sq[k+1].root <= {sq[k].root[30:0], fits};
      sq[k+1].x <= sq[k].x;
      sq[k+1].y <= sq[k].y;
      sq[k+1].z <= sq[k].z;
    end
  end

  // operand setup for both lanes
  logic cs_v [0:N];
  cs_t cs [0:N];
  logic signed [d2py_pkg::OPND_W-1:0] yx0, yy0, pz0;
  always_comb begin
    yx0 = {{8{sq[ROOT_STEPS].x[31]}}, sq[ROOT_STEPS].x, 24'b0};
    yy0 = {{8{sq[ROOT_STEPS].y[31]}}, sq[ROOT_STEPS].y, 24'b0};
    pz0 = {{8{sq[ROOT_STEPS].z[31]}}, sq[ROOT_STEPS].z, 24'b0};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      cs_v[0] <= 1'b0;
    end else begin
      cs_v[0] <= sq_v[ROOT_STEPS];
    end
    cs[0].px <= {8'b0, sq[ROOT_STEPS].root, 24'b0};
    cs[0].py <= -pz0;
    cs[0].pa <= '0;
    // left half plane: rotate by 180 first
    if (sq[ROOT_STEPS].x < 0) begin
      cs[0].yx <= -yx0;
      cs[0].yy <= -yy0;
      cs[0].ya <= (sq[ROOT_STEPS].y >= 0) ? d2py_pkg::DEG180_Q24 : -d2py_pkg::DEG180_Q24;
    end else begin
      cs[0].yx <= yx0;
      cs[0].yy <= yy0;
      cs[0].ya <= '0;
    end
    cs[0].vert <= (sq[ROOT_STEPS].x == 0) && (sq[ROOT_STEPS].y == 0);
    cs[0].zpos <= (sq[ROOT_STEPS].z > 0);
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    localparam logic signed [d2py_pkg::ANG_W-1:0] ATN = d2py_pkg::atan_q24(i);
    always_ff @(posedge clk) begin
      if (rst) begin
        cs_v[i+1] <= 1'b0;
      end else begin
        cs_v[i+1] <= cs_v[i];
      end
      if (cs[i].py >= 0) begin
        cs[i+1].px <= cs[i].px + (cs[i].py >>> i);
        cs[i+1].py <= cs[i].py - (cs[i].px >>> i);
        cs[i+1].pa <= cs[i].pa + ATN;
      end else begin
        cs[i+1].px <= cs[i].px - (cs[i].py >>> i);
        cs[i+1].py <= cs[i].py + (cs[i].px >>> i);
        cs[i+1].pa <= cs[i].pa - ATN;
      end
      if (cs[i].yy >= 0) begin
        cs[i+1].yx <= cs[i].yx + (cs[i].yy >>> i);
        cs[i+1].yy <= cs[i].yy - (cs[i].yx >>> i);
        cs[i+1].ya <= cs[i].ya + ATN;
      end else begin
        cs[i+1].yx <= cs[i].yx - (cs[i].yy >>> i);
        cs[i+1].yy <= cs[i].yy + (cs[i].yx >>> i);
        cs[i+1].ya <= cs[i].ya - ATN;
      end
      cs[i+1].vert <= cs[i].vert;
      cs[i+1].zpos <= cs[i].zpos;
    end
  end

  // round half up to 16 fraction bits
  logic rnd_v, rnd_vert, rnd_zpos;
  logic signed [27:0] rnd_p, rnd_y;
  logic signed [d2py_pkg::ANG_W-1:0] pr, yr;
  always_comb begin
    pr = (cs[N].pa + 40'sd128) >>> 8;
    yr = (cs[N].ya + 40'sd128) >>> 8;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_v <= 1'b0;
    end else begin
      rnd_v <= cs_v[N];
    end
    rnd_p <= pr[27:0];
    rnd_y <= yr[27:0];
    rnd_vert <= cs[N].vert;
    rnd_zpos <= cs[N].zpos;
  end

  // wrap into [0,360)
  function automatic logic [d2py_pkg::DEG_W-1:0] wrap(input logic signed [27:0] r);
    logic signed [27:0] d360;
    logic signed [27:0] w;
    d360 = $signed({3'b0, d2py_pkg::DEG360_Q16});
    w = r;
    if (w < 0) begin
      w = w + d360;
    end
    if (w >= d360) begin
      w = w - d360;
    end
    return w[d2py_pkg::DEG_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rnd_v;
    end
    if (rnd_vert) begin
      angles.pitch_deg <= rnd_zpos ? d2py_pkg::DEG270_Q16 : d2py_pkg::DEG90_Q16;
      angles.yaw_deg <= '0;
    end else begin
      angles.pitch_deg <= wrap(rnd_p);
      angles.yaw_deg <= wrap(rnd_y);
    end
  end

endmodule

>>> rtl/d2py_checker.sv
module d2py_checker #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input d2py_pkg::dir_t    dir,
  input logic              done,
  input d2py_pkg::angles_t angles
);

  localparam int unsigned N = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int unsigned LAT = N + 38;

  // every result traces back to an item taken a fixed time earlier
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without matching item");

  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (angles.pitch_deg < d2py_pkg::DEG360_Q16) &&
             (angles.yaw_deg < d2py_pkg::DEG360_Q16))
    else $error("angle out of range");

  // vertical vector gives zero yaw and a pitch of 90 or 270
  a_vertical: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && dir.dir_x == 0 && dir.dir_y == 0, LAT)) |->
      (angles.yaw_deg == '0) &&
      ((angles.pitch_deg == d2py_pkg::DEG90_Q16) ||
       (angles.pitch_deg == d2py_pkg::DEG270_Q16)))
    else $error("vertical case wrong");

endmodule

bind direction_to_pitch_yaw d2py_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_d2py_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .dir(dir),
  .done(done),
  .angles(angles)
);
